// File: design/cdgrs_pkg.sv
// Shared types, register indexes, op codes and the RGB565 packing function
// for the rectangle scan-out unit. No dependencies.
package cdgrs_pkg;

  localparam int GW = 13;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 40;
  localparam int OFFS_W = 18;
  localparam int PIX_W = 16;
  localparam int OUT_Q_DEPTH = 8;

  localparam logic [1:0] OP_WR_SCREEN = 2'd0;
  localparam logic [1:0] OP_WR_PAL = 2'd1;
  localparam logic [1:0] OP_EMIT = 2'd2;

  localparam logic [2:0] REG_SCROLL_H = 3'd0;
  localparam logic [2:0] REG_SCROLL_V = 3'd1;
  localparam logic [2:0] REG_RECT_LEFT = 3'd2;
  localparam logic [2:0] REG_RECT_TOP = 3'd3;
  localparam logic [2:0] REG_RECT_WIDTH = 3'd4;
  localparam logic [2:0] REG_RECT_HEIGHT = 3'd5;
  localparam logic [2:0] REG_DEST_STRIDE = 3'd6;

  typedef struct packed {
    logic [3:0]        scroll_h;
    logic [3:0]        scroll_v;
    logic signed [9:0] rect_left;
    logic signed [8:0] rect_top;
    logic [8:0]        rect_width;
    logic [7:0]        rect_height;
    logic [9:0]        dest_stride;
  } cfg_t;

  typedef struct packed {
    logic       empty;
    logic       last;
    logic [7:0] row;
    logic [8:0] col;
  } rast_t;

  typedef struct packed {
    logic              last;
    logic              empty;
    logic [OFFS_W-1:0] offset;
    logic [PIX_W-1:0]  pixel;
  } result_t;

  function automatic logic [PIX_W-1:0] to_rgb565(input logic [23:0] rgb);
    return {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

endpackage

// File: design/cdg_rect_scanout_rgb565_unit.sv
// Channel    | Dir | Beat contents
// s_axis     | in  | tdata: location[15:0], value[39:16]; tuser: op[1:0]
// m_axis     | out | tdata: pixel[15:0], dest_offset[33:16]; tuser: empty_res; tlast: last
// cfg        | in  | cfg_wr_en, cfg_addr (register index), cfg_wdata
// One beat per cycle is accepted while s_axis_tready is high.
// Latency is set by the screen RAM read followed by the palette RAM read.
// Synchronous reset clears the counters, pipeline and queue and sets register defaults.
// Input tready drops only when eight emit results are pending downstream.
// Top level of the rectangle scan-out unit. Depends on cdgrs_pkg, cdgrs_ram,
// cdgrs_raster and cdgrs_fifo.
module cdg_rect_scanout_rgb565_unit import cdgrs_pkg::*; #(
  parameter int SCREEN_W = 300,
  parameter int SCREEN_H = 216,
  parameter int VISIBLE_W = 288,
  parameter int VISIBLE_H = 192,
  parameter int TILE_W = 6,
  parameter int TILE_H = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // location[15:0], value[39:16]
  input  logic [1:0]            s_axis_tuser,   // op[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // pixel[15:0], dest_offset[33:16], zero
  output logic [0:0]            m_axis_tuser,   // empty_res[0]
  output logic                  m_axis_tlast,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_addr,
  input  logic [9:0]            cfg_wdata
);

  localparam int CELLS = SCREEN_W * SCREEN_H;
  localparam int SAW = $clog2(CELLS);
  localparam int SXW = $clog2(SCREEN_W);
  localparam int SYW = $clog2(SCREEN_H);
  localparam int PW = $clog2(OUT_Q_DEPTH + 1);

  cfg_t cfg;
  logic in_fire;
  logic out_fire;
  logic emit_fire;
  logic [PW-1:0] pend;

  rast_t rast;
  logic [SXW-1:0] rast_sx;
  logic [SYW-1:0] rast_sy;

  logic           s1_valid;
  logic [1:0]     s1_op;
  logic [15:0]    s1_loc;
  logic [23:0]    s1_val;
  rast_t          s1_info;
  logic [SXW-1:0] s1_sx;
  logic [SYW-1:0] s1_sy;

  logic              s2_valid;
  logic [1:0]        s2_op;
  logic              s2_pal_ok;
  logic [3:0]        s2_pal_idx;
  logic [23:0]       s2_val;
  logic              s2_empty;
  logic              s2_last;
  logic [OFFS_W-1:0] s2_offset;

  logic              s3_valid;
  logic              s3_empty;
  logic              s3_last;
  logic [OFFS_W-1:0] s3_offset;

  logic           scr_en;
  logic           scr_we;
  logic [SAW-1:0] scr_addr;
  logic [3:0]     scr_rdata;
  logic           pal_en;
  logic           pal_we;
  logic [3:0]     pal_addr;
  logic [23:0]    pal_rdata;
  logic [OFFS_W-1:0] s1_offset;
  result_t        s3_result;
  result_t        q_head;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign emit_fire = in_fire && (s_axis_tuser == OP_EMIT);
  assign s_axis_tready = (pend < PW'(OUT_Q_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scroll_h <= 4'd0;
      cfg.scroll_v <= 4'd0;
      cfg.rect_left <= 10'sd0;
      cfg.rect_top <= 9'sd0;
      cfg.rect_width <= 9'd288;
      cfg.rect_height <= 8'd192;
      cfg.dest_stride <= 10'd288;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SCROLL_H: cfg.scroll_h <= cfg_wdata[3:0];
        REG_SCROLL_V: cfg.scroll_v <= cfg_wdata[3:0];
        REG_RECT_LEFT: cfg.rect_left <= signed'(cfg_wdata);
        REG_RECT_TOP: cfg.rect_top <= signed'(cfg_wdata[8:0]);
        REG_RECT_WIDTH: cfg.rect_width <= cfg_wdata[8:0];
        REG_RECT_HEIGHT: cfg.rect_height <= cfg_wdata[7:0];
        REG_DEST_STRIDE: cfg.dest_stride <= cfg_wdata;
        default: cfg.scroll_h <= cfg.scroll_h;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      case ({emit_fire, out_fire})
        2'b10: pend <= pend + 1'b1;
        2'b01: pend <= pend - 1'b1;
        default: pend <= pend;
      endcase
    end
  end

  cdgrs_raster #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H),
    .VISIBLE_W(VISIBLE_W),
    .VISIBLE_H(VISIBLE_H),
    .TILE_W   (TILE_W),
    .TILE_H   (TILE_H)
  ) u_raster (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .step(emit_fire),
    .info(rast),
    .sx  (rast_sx),
    .sy  (rast_sy)
  );

  // Stage 1: screen RAM access.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_op <= s_axis_tuser;
    s1_loc <= s_axis_tdata[15:0];
    s1_val <= s_axis_tdata[39:16];
    s1_info <= rast;
    s1_sx <= rast_sx;
    s1_sy <= rast_sy;
  end

  always_comb begin
    logic loc_ok;
    loc_ok = (32'(s1_loc) < 32'(CELLS));
    scr_we = (s1_op == OP_WR_SCREEN);
    scr_en = s1_valid && ((scr_we && loc_ok) || (s1_op == OP_EMIT && !s1_info.empty));
    scr_addr = scr_we ? SAW'(s1_loc) : SAW'(SAW'(s1_sy) * SAW'(SCREEN_W) + SAW'(s1_sx));
    s1_offset = OFFS_W'(s1_info.row) * OFFS_W'(cfg.dest_stride) + OFFS_W'(s1_info.col);
  end

  cdgrs_ram #(
    .WIDTH(4),
    .DEPTH(CELLS)
  ) u_screen_ram (
    .clk  (clk),
    .en   (scr_en),
    .we   (scr_we),
    .addr (scr_addr),
    .wdata(s1_val[3:0]),
    .rdata(scr_rdata)
  );

  // Stage 2: palette RAM access.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_op <= s1_op;
    s2_pal_ok <= (s1_loc[15:4] == 12'd0);
    s2_pal_idx <= s1_loc[3:0];
    s2_val <= s1_val;
    s2_empty <= s1_info.empty;
    s2_last <= s1_info.last || s1_info.empty;
    s2_offset <= s1_info.empty ? '0 : s1_offset;
  end

  assign pal_we = (s2_op == OP_WR_PAL);
  assign pal_en = s2_valid && ((pal_we && s2_pal_ok) || (s2_op == OP_EMIT && !s2_empty));
  assign pal_addr = pal_we ? s2_pal_idx : scr_rdata;

  cdgrs_ram #(
    .WIDTH(24),
    .DEPTH(16)
  ) u_palette_ram (
    .clk  (clk),
    .en   (pal_en),
    .we   (pal_we),
    .addr (pal_addr),
    .wdata(s2_val),
    .rdata(pal_rdata)
  );

  // Stage 3: color packing into the result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid && (s2_op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    s3_empty <= s2_empty;
    s3_last <= s2_last;
    s3_offset <= s2_offset;
  end

  always_comb begin
    s3_result.last = s3_last;
    s3_result.empty = s3_empty;
    s3_result.offset = s3_offset;
    s3_result.pixel = s3_empty ? '0 : to_rgb565(pal_rdata);
  end

  cdgrs_fifo #(
    .DEPTH(OUT_Q_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst      (rst),
    .push     (s3_valid),
    .push_data(s3_result),
    .pop      (out_fire),
    .valid    (m_axis_tvalid),
    .head     (q_head)
  );

  assign m_axis_tdata = {(OUT_DATA_W - OFFS_W - PIX_W)'(0), q_head.offset, q_head.pixel};
  assign m_axis_tuser = q_head.empty;
  assign m_axis_tlast = q_head.last;

endmodule

// File: design/cdgrs_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module cdgrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: design/cdgrs_raster.sv
// Rectangle clipping, raster position counters and screen coordinate
// computation for each emit beat. Depends on cdgrs_pkg.
module cdgrs_raster import cdgrs_pkg::*; #(
  parameter int SCREEN_W = 300,
  parameter int SCREEN_H = 216,
  parameter int VISIBLE_W = 288,
  parameter int VISIBLE_H = 192,
  parameter int TILE_W = 6,
  parameter int TILE_H = 12,
  localparam int SXW = $clog2(SCREEN_W),
  localparam int SYW = $clog2(SCREEN_H)
) (
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  input  logic           step,
  output rast_t          info,
  output logic [SXW-1:0] sx,
  output logic [SYW-1:0] sy
);

  localparam logic signed [GW-1:0] VIS_W = GW'(VISIBLE_W);
  localparam logic signed [GW-1:0] VIS_H = GW'(VISIBLE_H);
  localparam logic signed [GW-1:0] X_MAX = GW'(SCREEN_W - 1);
  localparam logic signed [GW-1:0] Y_MAX = GW'(SCREEN_H - 1);
  localparam logic signed [GW-1:0] TW = GW'(TILE_W);
  localparam logic signed [GW-1:0] TH = GW'(TILE_H);
  localparam logic signed [GW-1:0] ONE = GW'(1);
  localparam logic signed [GW-1:0] ZERO = GW'(0);

  logic [7:0] row;
  logic [8:0] col;
  logic [7:0] row_next;
  logic [8:0] col_next;

  always_comb begin
    logic signed [GW-1:0] x0, y0, w, h, xs, ys, cw, ch, sx_raw, sy_raw;
    logic signed [GW-1:0] row_s, col_s, stride_s;
    logic [4:0] hx, vy;
    logic off, restart, col_end, row_end;
    logic [7:0] cur_row;
    logic [8:0] cur_col;
    x0 = GW'(cfg.rect_left);
    y0 = GW'(cfg.rect_top);
    w = signed'(GW'(cfg.rect_width));
    h = signed'(GW'(cfg.rect_height));
    stride_s = signed'(GW'(cfg.dest_stride));
    if (x0 < ZERO) begin
      cw = w + x0;
      xs = ZERO;
    end else begin
      cw = w;
      xs = x0;
    end
    if (y0 < ZERO) begin
      ch = h + y0;
      ys = ZERO;
    end else begin
      ch = h;
      ys = y0;
    end
    off = (xs >= VIS_W) || (ys >= VIS_H);
    if (xs + cw > VIS_W) begin
      cw = VIS_W - xs;
    end
    if (ys + ch > VIS_H) begin
      ch = VIS_H - ys;
    end
    info.empty = (cfg.rect_width == 9'd0) || (cfg.rect_height == 8'd0) || off ||
                 (cw <= ZERO) || (ch <= ZERO) || (stride_s < cw);

    row_s = signed'(GW'(row));
    col_s = signed'(GW'(col));
    restart = (row_s >= ch) || (col_s >= cw);
    cur_row = restart ? 8'd0 : row;
    cur_col = restart ? 9'd0 : col;

    col_end = signed'(GW'(cur_col)) + ONE >= cw;
    row_end = signed'(GW'(cur_row)) + ONE >= ch;
    info.last = col_end && row_end;
    info.row = cur_row;
    info.col = cur_col;

    if (info.empty) begin
      row_next = 8'd0;
      col_next = 9'd0;
    end else if (!col_end) begin
      row_next = cur_row;
      col_next = 9'(cur_col + 9'd1);
    end else if (!row_end) begin
      row_next = 8'(cur_row + 8'd1);
      col_next = 9'd0;
    end else begin
      row_next = 8'd0;
      col_next = 9'd0;
    end

    hx = ({1'b0, cfg.scroll_h} >= 5'(TILE_W)) ? 5'(TILE_W - 1) : {1'b0, cfg.scroll_h};
    vy = ({1'b0, cfg.scroll_v} >= 5'(TILE_H)) ? 5'(TILE_H - 1) : {1'b0, cfg.scroll_v};
    sx_raw = xs + signed'(GW'(cur_col)) + TW + signed'(GW'(hx));
    sy_raw = ys + signed'(GW'(cur_row)) + TH + signed'(GW'(vy));
    sx = (sx_raw > X_MAX) ? SXW'(SCREEN_W - 1) : SXW'(sx_raw);
    sy = (sy_raw > Y_MAX) ? SYW'(SCREEN_H - 1) : SYW'(sy_raw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= 8'd0;
      col <= 9'd0;
    end else if (step) begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

// File: design/cdgrs_fifo.sv
// Small register-based result queue that decouples the memory pipeline from
// the output handshake. Depends on cdgrs_pkg.
module cdgrs_fifo import cdgrs_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    valid,
  output result_t head
);

  localparam int AW = $clog2(DEPTH);

  result_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + 1'b1);
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/cdgrs_checker.sv
// Port-level checks for the rectangle scan-out unit, bound to the top level.
// Depends on cdgrs_pkg.
module cdgrs_checker import cdgrs_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]            m_axis_tuser,
  input logic                  m_axis_tlast
);

  // A stalled result beat keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // An empty result is always the last beat and carries no pixel or offset.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("empty result malformed");

  // Input backpressure only happens while results wait at the output.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending output");

  // Nothing is presented right after reset.
  assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("result beat right after reset");

endmodule

bind cdg_rect_scanout_rgb565_unit cdgrs_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

// File: tb/sv/scanout_checker.sv
// Scoreboard for the rectangle scan-out unit. It mirrors the screen, the palette,
// the registers and the raster position, predicts every emitted pixel and checks
// each output beat against it. Depends on cdgrs_pkg.
module scanout_checker import cdgrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // location[15:0], value[39:16]
  input  logic [1:0]            s_axis_tuser,   // op[1:0]
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // pixel[15:0], dest_offset[33:16]
  input  logic [0:0]            m_axis_tuser,   // empty_res[0]
  input  logic                  m_axis_tlast,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_addr,
  input  logic [9:0]            cfg_wdata,
  output int                    fails,
  output int                    outstanding
);

  localparam int SCR_W = 300;
  localparam int SCR_H = 216;
  localparam int VIS_W = 288;
  localparam int VIS_H = 192;
  localparam int TILE_W = 6;
  localparam int TILE_H = 12;
  localparam int SCR_CELLS = SCR_W * SCR_H;

  logic [3:0]  screen [SCR_CELLS];
  logic [23:0] palette [16];
  cfg_t        regs;
  int          row_pos;
  int          col_pos;
  result_t     pending_pixels [$];

  function automatic result_t next_scan_pixel();
    int x0, y0, w, h, hx, vy, sx, sy;
    logic [3:0] ci;
    logic [23:0] rgb;
    result_t r;
    r = '0;
    x0 = $signed(regs.rect_left);
    y0 = $signed(regs.rect_top);
    w = int'(regs.rect_width);
    h = int'(regs.rect_height);
    if (w > 0 && h > 0) begin
      if (x0 < 0) begin
        w += x0;
        x0 = 0;
      end
      if (y0 < 0) begin
        h += y0;
        y0 = 0;
      end
      if (x0 >= VIS_W || y0 >= VIS_H) begin
        w = 0;
      end else begin
        if (x0 + w > VIS_W) w = VIS_W - x0;
        if (y0 + h > VIS_H) h = VIS_H - y0;
      end
    end
    if (w <= 0 || h <= 0 || int'(regs.dest_stride) < w) begin
      row_pos = 0;
      col_pos = 0;
      r.empty = 1'b1;
      r.last = 1'b1;
      return r;
    end
    // A rectangle that shrank under the raster position restarts the scan.
    if (row_pos >= h || col_pos >= w) begin
      row_pos = 0;
      col_pos = 0;
    end
    hx = (regs.scroll_h >= TILE_W) ? TILE_W - 1 : int'(regs.scroll_h);
    vy = (regs.scroll_v >= TILE_H) ? TILE_H - 1 : int'(regs.scroll_v);
    sx = x0 + col_pos + TILE_W + hx;
    sy = y0 + row_pos + TILE_H + vy;
    if (sx < 0) sx = 0;
    if (sx > SCR_W - 1) sx = SCR_W - 1;
    if (sy < 0) sy = 0;
    if (sy > SCR_H - 1) sy = SCR_H - 1;
    ci = screen[sy * SCR_W + sx];
    rgb = palette[ci];
    r.pixel = {rgb[23:19], rgb[15:10], rgb[7:3]};
    r.offset = OFFS_W'(row_pos * int'(regs.dest_stride) + col_pos);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
        r.last = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    logic [15:0] loc;
    logic [23:0] val;
    if (rst) begin
      regs.scroll_h = '0;
      regs.scroll_v = '0;
      regs.rect_left = '0;
      regs.rect_top = '0;
      regs.rect_width = 9'd288;
      regs.rect_height = 8'd192;
      regs.dest_stride = 10'd288;
      row_pos = 0;
      col_pos = 0;
      pending_pixels.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_SCROLL_H: regs.scroll_h = cfg_wdata[3:0];
          REG_SCROLL_V: regs.scroll_v = cfg_wdata[3:0];
          REG_RECT_LEFT: regs.rect_left = cfg_wdata[9:0];
          REG_RECT_TOP: regs.rect_top = cfg_wdata[8:0];
          REG_RECT_WIDTH: regs.rect_width = cfg_wdata[8:0];
          REG_RECT_HEIGHT: regs.rect_height = cfg_wdata[7:0];
          REG_DEST_STRIDE: regs.dest_stride = cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_pixels.size() == 0) begin
          fails++;
          $display("%0t: unexpected beat, expected none, actual pixel 0x%0h offset 0x%0h",
                   $time, m_axis_tdata[15:0], m_axis_tdata[33:16]);
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel", want.pixel, m_axis_tdata[15:0]);
          check_field("dest_offset", want.offset, m_axis_tdata[33:16]);
          check_field("empty_res", want.empty, m_axis_tuser[0]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        loc = s_axis_tdata[15:0];
        val = s_axis_tdata[39:16];
        case (s_axis_tuser)
          OP_WR_SCREEN: if (loc < SCR_CELLS) screen[loc] = val[3:0];
          OP_WR_PAL: if (loc < 16) palette[loc[3:0]] = val;
          OP_EMIT: pending_pixels.push_back(next_scan_pixel());
          default: ;
        endcase
      end
    end
    outstanding = pending_pixels.size();
  end

endmodule

// File: tb/sv/testbench.sv
// Top of the scan-out unit testbench: clock, reset, register programming and the
// beat stimulus with random idling on both channels. Checking is done by
// scanout_checker; depends on cdgrs_pkg, the unit and the checker.
module testbench;
  import cdgrs_pkg::*;

  localparam int SCR_W = 300;
  localparam int SCR_H = 216;
  localparam int VIS_W = 288;
  localparam int VIS_H = 192;
  localparam int TILE_W = 6;
  localparam int TILE_H = 12;
  localparam int SCR_CELLS = SCR_W * SCR_H;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int SCAN_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_wr_en;
  logic [2:0]            cfg_addr;
  logic [9:0]            cfg_wdata;
  int                    fails;
  int                    outstanding;

  bit screen_written [SCR_CELLS];
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  int cycles = 0;
  int scan_count = 0;
  int sh_q, sv_q, left_q, top_q, width_q, height_q, stride_q;

  cdg_rect_scanout_rgb565_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  scanout_checker chk (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .fails(fails),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int gap;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      gap = rx_gaps_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [15:0] loc,
                           input logic [23:0] val);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {val, loc};
    do @(posedge clk); while (!s_axis_tready);
    if (op == OP_WR_SCREEN && loc < SCR_CELLS) screen_written[loc] = 1'b1;
    scan_count++;
  endtask

  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= 10'(data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void clip_rect(output int x0, output int y0, output int w, output int h);
    x0 = left_q;
    y0 = top_q;
    w = width_q;
    h = height_q;
    if (w > 0 && h > 0) begin
      if (x0 < 0) begin
        w += x0;
        x0 = 0;
      end
      if (y0 < 0) begin
        h += y0;
        y0 = 0;
      end
      if (x0 >= VIS_W || y0 >= VIS_H) begin
        w = 0;
      end else begin
        if (x0 + w > VIS_W) w = VIS_W - x0;
        if (y0 + h > VIS_H) h = VIS_H - y0;
      end
    end
    if (w < 0) w = 0;
    if (h < 0) h = 0;
  endfunction

  // Writes the registers from the shadow copies, then fills every screen cell
  // that the new rectangle can read and that has not been written yet.
  task automatic program_regs();
    int x0, y0, w, h, hx, vy, sx, sy;
    settle();
    write_reg(REG_SCROLL_H, sh_q);
    write_reg(REG_SCROLL_V, sv_q);
    write_reg(REG_RECT_LEFT, left_q);
    write_reg(REG_RECT_TOP, top_q);
    write_reg(REG_RECT_WIDTH, width_q);
    write_reg(REG_RECT_HEIGHT, height_q);
    write_reg(REG_DEST_STRIDE, stride_q);
    clip_rect(x0, y0, w, h);
    hx = (sh_q >= TILE_W) ? TILE_W - 1 : sh_q;
    vy = (sv_q >= TILE_H) ? TILE_H - 1 : sv_q;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        sx = x0 + c + TILE_W + hx;
        sy = y0 + r + TILE_H + vy;
        if (sx > SCR_W - 1) sx = SCR_W - 1;
        if (sy > SCR_H - 1) sy = SCR_H - 1;
        if (!screen_written[sy * SCR_W + sx]) begin
          send_item(OP_WR_SCREEN, 16'(sy * SCR_W + sx), 24'($urandom));
        end
      end
    end
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 4))
      0: send_item(OP_WR_SCREEN, 16'($urandom_range(0, SCR_CELLS - 1)), 24'($urandom));
      1: send_item(OP_WR_SCREEN, 16'($urandom_range(SCR_CELLS, 65535)), 24'($urandom));
      2: send_item(OP_WR_PAL, 16'($urandom_range(0, 15)), 24'($urandom));
      3: send_item(OP_WR_PAL, 16'($urandom_range(16, 65535)), 24'($urandom));
      default: send_item(OP_NOP, 16'($urandom), 24'($urandom));
    endcase
  endtask

  task automatic scan_pixels(input int n, input int noise_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) noise_item();
      else send_item(OP_EMIT, 16'($urandom), 24'($urandom));
    end
  endtask

  task automatic directed_phase(input int sh, input int sv, input int left, input int top,
                                input int width, input int height, input int stride,
                                input int n);
    sh_q = sh;
    sv_q = sv;
    left_q = left;
    top_q = top;
    width_q = width;
    height_q = height;
    stride_q = stride;
    program_regs();
    scan_pixels(n, 0);
  endtask

  // Mostly small rectangles anywhere on the visible area, plus wide strips,
  // tall strips and degenerate settings that give empty results.
  task automatic random_phase();
    int x0, y0, w, h, area, n;
    sh_q = $urandom_range(0, 15);
    sv_q = $urandom_range(0, 15);
    left_q = $urandom_range(0, 299) - 8;
    top_q = $urandom_range(0, 199) - 8;
    width_q = $urandom_range(1, 12);
    height_q = $urandom_range(1, 6);
    case ($urandom_range(0, 9))
      6: begin
        left_q = $urandom_range(0, 1023) - 512;
        width_q = $urandom_range(0, 511);
        height_q = $urandom_range(1, 2);
      end
      7: begin
        top_q = $urandom_range(0, 511) - 256;
        height_q = $urandom_range(0, 255);
        width_q = $urandom_range(1, 2);
      end
      8: begin
        case ($urandom_range(0, 3))
          0: width_q = 0;
          1: height_q = 0;
          2: left_q = $urandom_range(VIS_W, 511);
          default: top_q = $urandom_range(VIS_H, 255);
        endcase
      end
      default: ;
    endcase
    clip_rect(x0, y0, w, h);
    case ($urandom_range(0, 9))
      0: stride_q = $urandom_range(0, 1023);
      1, 2: stride_q = (w > 0) ? w : 1;
      default: stride_q = $urandom_range((w > 0) ? w : 1, 1023);
    endcase
    area = (w > 0 && h > 0 && stride_q >= w) ? w * h : 1;
    n = $urandom_range(1, area + area / 4 + 2);
    if (n > 60) n = $urandom_range(20, 60);
    tx_gaps_on = $urandom_range(0, 3) != 0;
    rx_gaps_on = $urandom_range(0, 3) != 0;
    program_regs();
    scan_pixels(n, 15);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_WR_SCREEN;
    cfg_wr_en = 1'b0;
    cfg_addr = REG_SCROLL_H;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(OP_WR_PAL, 16'd0, 24'h000000);
    send_item(OP_WR_PAL, 16'd15, 24'hFFFFFF);
    for (int i = 1; i < 15; i++) send_item(OP_WR_PAL, 16'(i), 24'($urandom));
    send_item(OP_WR_PAL, 16'd16, 24'hFFFFFF);
    send_item(OP_WR_PAL, 16'hFFFF, 24'hFFFFFF);
    send_item(OP_WR_SCREEN, 16'(SCR_CELLS), 24'hFFFFFF);
    send_item(OP_WR_SCREEN, 16'hFFFF, 24'hFFFFFF);
    send_item(OP_NOP, 16'hFFFF, 24'hFFFFFF);

    // Empty settings: zero width, zero height, origin past the visible area,
    // negative origin clipping everything, stride below width, stride zero.
    directed_phase(0, 0, 0, 0, 0, 192, 288, 1);
    directed_phase(0, 0, 0, 0, 288, 0, 288, 1);
    directed_phase(0, 0, 511, 255, 511, 255, 1023, 1);
    directed_phase(0, 0, -512, -256, 511, 255, 1023, 1);
    directed_phase(15, 15, 0, 0, 3, 2, 2, 1);
    directed_phase(6, 12, 0, 0, 1, 1, 0, 1);
    // Clipped corners, full scans with wrap-around, saturated scroll.
    directed_phase(15, 15, -2, -1, 5, 3, 1023, 7);
    directed_phase(5, 11, 285, 190, 511, 255, 3, 6);
    // Rectangle shrinks under the raster position.
    directed_phase(7, 3, 10, 10, 4, 4, 4, 6);
    directed_phase(7, 3, 10, 10, 2, 2, 2, 2);

    scan_count = 0;
    while (scan_count < SCAN_ITEMS) random_phase();

    settle();
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/cdgrs_pkg.sv
design/cdgrs_ram.sv
design/cdgrs_raster.sv
design/cdgrs_fifo.sv
design/cdg_rect_scanout_rgb565_unit.sv
design/cdgrs_checker.sv
tb/sv/scanout_checker.sv
tb/sv/testbench.sv
